// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the motion mask block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define TMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/tmm_pkg.sv -----
// Package with the constants and types of the temporal median motion mask.
`timescale 1ns / 1ps
`default_nettype none

package tmm_pkg;

  // Number of frames kept per pixel position.
  localparam int HISTORY_DEPTH = 5;
  // Largest frame, in pixels.
  localparam int MAX_PIXELS    = 262144;

  localparam int POS_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int LEN_W      = $clog2(MAX_PIXELS + 1);
  localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int MEDIAN_IDX = HISTORY_DEPTH / 2;

  // Division by three of a sum up to 765: (sum * 683) >> 11 is exact.
  localparam int SUM_W      = 10;
  localparam int PROD_W     = 20;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  // Register fields.
  localparam int THRESH_W    = 8;
  localparam int FRAME_LEN_W = 19;
  localparam logic [THRESH_W-1:0]    THRESH_RESET    = 8'd20;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 19'd76800;

  // Register indexes, taken from the word address.
  localparam logic REG_THRESHOLD    = 1'b0;
  localparam logic REG_FRAME_PIXELS = 1'b1;

  // One history row: the grey bytes of all slots for one pixel position.
  typedef logic [HISTORY_DEPTH-1:0][7:0] hist_row_t;

endpackage

`default_nettype wire

// ----- sv/tmm_median.sv -----
// Temporal median of one history row and threshold compare against the new grey value.
`timescale 1ns / 1ps
`default_nettype none

module tmm_median (
  input  tmm_pkg::hist_row_t                  row_i,
  input  logic [7:0]                          grey_i,
  input  logic [tmm_pkg::THRESH_W-1:0]        threshold_i,
  output logic                                motion_o
);

  logic [tmm_pkg::SLOT_W-1:0] rank [tmm_pkg::HISTORY_DEPTH];
  logic [7:0]                 median;
  logic [7:0]                 diff;

  // Each value's place in the sorted order; ties are broken by slot number.
  always_comb begin
    for (int i = 0; i < tmm_pkg::HISTORY_DEPTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < tmm_pkg::HISTORY_DEPTH; j++) begin
        if (j != i) begin
          if ((row_i[j] < row_i[i]) || ((row_i[j] == row_i[i]) && (j < i))) begin
            rank[i] = rank[i] + tmm_pkg::SLOT_W'(1);
          end
        end
      end
    end
  end

  // Exactly one value holds the middle place.
  always_comb begin
    median = '0;
    for (int i = 0; i < tmm_pkg::HISTORY_DEPTH; i++) begin
      if (rank[i] == tmm_pkg::SLOT_W'(tmm_pkg::MEDIAN_IDX)) begin
        median = median | row_i[i];
      end
    end
  end

  // Absolute difference against the threshold.
  assign diff     = (median > grey_i) ? (median - grey_i) : (grey_i - median);
  assign motion_o = (diff > threshold_i);

endmodule

`default_nettype wire

// ----- sv/temporal_median_motion_mask.sv -----
// Top level of the temporal median motion mask: control, history memory and result stage.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata: chan_a, chan_b, chan_c
// m_axis    out        m_axis_tvalid/tready        tdata: motion; tlast: frame_end
// apb       in         psel/penable/pwrite/pready  0x0 threshold, 0x4 frame_pixels
//
// One pixel is taken in every cycle while the result side does not stall; its result
// passes through the input stage and the result register. The history row is read from a
// single memory at acceptance and the new grey byte is written back as the pixel leaves
// the input stage, which a stalled result can delay, with a bypass for back-to-back hits
// on the same row. During the first five frames pixels are consumed without any result.
// A stalled result holds the result register; one more pixel can still be held in the
// input stage. Reset clears control state only; the history memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module temporal_median_motion_mask (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
  // Result stream out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // motion [0], zero padding [7:1]
  output logic        m_axis_tlast,   // frame_end
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int HD     = tmm_pkg::HISTORY_DEPTH;
  localparam int POS_W  = tmm_pkg::POS_W;
  localparam int LEN_W  = tmm_pkg::LEN_W;
  localparam int SLOT_W = tmm_pkg::SLOT_W;

  // Configuration registers.
  logic [tmm_pkg::THRESH_W-1:0]    threshold_q;
  logic [tmm_pkg::FRAME_LEN_W-1:0] frame_pixels_q;

  // Frame position state.
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              filled_q, filled_d;

  // Input stage.
  logic              s1_valid_q;
  logic [7:0]        s1_grey_q;
  logic [POS_W-1:0]  s1_pos_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              s1_emit_q;
  logic              s1_last_q;
  logic              fwd_hit_q;
  logic [SLOT_W-1:0] fwd_slot_q;
  logic [7:0]        fwd_grey_q;
  tmm_pkg::hist_row_t rd_row_q;

  // Result register.
  logic out_valid_q, out_valid_d;
  logic out_motion_q;
  logic out_last_q;

  // History memory, one row of all slots per pixel position.
  tmm_pkg::hist_row_t hist_mem [tmm_pkg::MAX_PIXELS];

  logic                      in_acc;
  logic                      s1_adv;
  logic [tmm_pkg::SUM_W-1:0] grey_sum;
  logic [tmm_pkg::PROD_W-1:0] grey_prod;
  logic [7:0]                grey_in;
  logic [LEN_W-1:0]          eff_len;
  logic [LEN_W-1:0]          pos_plus1;
  logic                      last_in;
  logic                      cfg_wr;
  tmm_pkg::hist_row_t        row_cur;
  logic                      motion;

  // Configuration writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= tmm_pkg::THRESH_RESET;
      frame_pixels_q <= tmm_pkg::FRAME_LEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tmm_pkg::REG_THRESHOLD:    threshold_q    <= pwdata[tmm_pkg::THRESH_W-1:0];
        tmm_pkg::REG_FRAME_PIXELS: frame_pixels_q <= pwdata[tmm_pkg::FRAME_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tmm_pkg::REG_THRESHOLD:    prdata = 32'(threshold_q);
      tmm_pkg::REG_FRAME_PIXELS: prdata = 32'(frame_pixels_q);
      default:                   prdata = '0;
    endcase
  end

  // Handshakes: the input stage moves on when its result has room or it has none.
  assign s1_adv        = s1_valid_q && (!s1_emit_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Grey value as a reciprocal multiply.
  assign grey_sum  = tmm_pkg::SUM_W'(s_axis_tdata[7:0]) + tmm_pkg::SUM_W'(s_axis_tdata[15:8])
                   + tmm_pkg::SUM_W'(s_axis_tdata[23:16]);
  assign grey_prod = tmm_pkg::PROD_W'(grey_sum) * tmm_pkg::PROD_W'(tmm_pkg::DIV3_MUL);
  assign grey_in   = 8'(grey_prod >> tmm_pkg::DIV3_SHIFT);

  // Effective frame length: zero acts as one, oversized values are clamped.
  always_comb begin
    if (frame_pixels_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(frame_pixels_q) > 32'(tmm_pkg::MAX_PIXELS)) begin
      eff_len = LEN_W'(tmm_pkg::MAX_PIXELS);
    end else begin
      eff_len = LEN_W'(frame_pixels_q);
    end
  end

  assign pos_plus1 = LEN_W'(pos_q) + LEN_W'(1);
  assign last_in   = (pos_plus1 >= eff_len);

  // Next frame position, slot and fill flag.
  always_comb begin
    pos_d    = pos_q;
    slot_d   = slot_q;
    filled_d = filled_q;
    if (in_acc) begin
      if (last_in) begin
        pos_d  = '0;
        slot_d = (slot_q == SLOT_W'(HD - 1)) ? '0 : (slot_q + SLOT_W'(1));
        if (slot_q == SLOT_W'(HD - 1)) begin
          filled_d = 1'b1;
        end
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      slot_q   <= '0;
      filled_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      slot_q   <= slot_d;
      filled_q <= filled_d;
    end
  end

  // Input stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input stage payload, with a bypass for a write to the same row at this edge.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_grey_q  <= grey_in;
      s1_pos_q   <= pos_q;
      s1_slot_q  <= slot_q;
      s1_emit_q  <= filled_q;
      s1_last_q  <= last_in;
      fwd_hit_q  <= s1_adv && (s1_pos_q == pos_q);
      fwd_slot_q <= s1_slot_q;
      fwd_grey_q <= s1_grey_q;
    end
  end

  // History memory: row read at acceptance, byte write as the item leaves the stage.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_row_q <= hist_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      hist_mem[s1_pos_q][s1_slot_q] <= s1_grey_q;
    end
  end

  // Row as it stands after the bypassed byte and the new grey value.
  always_comb begin
    row_cur = rd_row_q;
    if (fwd_hit_q) begin
      row_cur[fwd_slot_q] = fwd_grey_q;
    end
    row_cur[s1_slot_q] = s1_grey_q;
  end

  tmm_median u_median (
    .row_i       (row_cur),
    .grey_i      (s1_grey_q),
    .threshold_i (threshold_q),
    .motion_o    (motion)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_emit_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_motion_q <= motion;
      out_last_q   <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_motion_q};
  assign m_axis_tlast  = out_last_q;

  // Assertions.
  `TMM_ASSERT(a_emit_only_filled, (s1_valid_q && s1_emit_q) |-> filled_q, "early result")
  `TMM_ASSERT(a_frame_wrap, (in_acc && last_in) |=> (pos_q == '0), "no wrap at frame end")
  `TMM_ASSERT_ALWAYS(a_slot_range, !rst_ni || (slot_q < SLOT_W'(HD)), "slot out of range")

endmodule

`default_nettype wire

// ----- verif/tmm_motion_checker.sv -----
// Checker that predicts and compares the motion mask results of the temporal median block.
`timescale 1ns / 1ps

module tmm_motion_checker
  import tmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel channel, observed.
  input  logic        pix_valid_i,
  input  logic        pix_ready_i,
  input  logic [23:0] pix_data_i,    // chan_a [7:0], chan_b [15:8], chan_c [23:16]
  // Result channel, observed.
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [7:0]  res_data_i,    // motion [0], zero padding [7:1]
  input  logic        res_last_i,    // frame_end
  // Configuration port, observed.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // Status for the stimulus side.
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic motion;
    logic frame_end;
  } motion_result_t;

  // Results that accepted pixels still owe, oldest first.
  motion_result_t motion_due[$];
  motion_result_t oldest_due;

  // Grey bytes kept per pixel position and slot, keyed by position * depth + slot.
  logic [7:0] grey_history [int];

  logic [THRESH_W-1:0]    threshold_q;
  logic [FRAME_LEN_W-1:0] frame_len_q;
  int                     slot_q;
  bit                     filled_q;
  int                     pos_q;
  int                     mismatches;

  // Reduce one pixel to grey, store it and work out the result it owes, if any.
  task automatic absorb_pixel(input logic [23:0] px);
    int grey;
    int len;
    int row_base;
    int median;
    int diff;
    int val;
    int j;
    int row [HISTORY_DEPTH];
    bit last;
    motion_result_t res;
    grey = (int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16])) / 3;
    if (frame_len_q == '0) begin
      len = 1;
    end else if (int'(frame_len_q) > MAX_PIXELS) begin
      len = MAX_PIXELS;
    end else begin
      len = int'(frame_len_q);
    end
    last = (pos_q + 1 >= len);
    row_base = pos_q * HISTORY_DEPTH;
    grey_history[row_base + slot_q] = grey[7:0];

    if (filled_q) begin
      // Insertion sort of the row; the median is the middle entry, upper one for even depth.
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        val = grey_history.exists(row_base + i) ? int'(grey_history[row_base + i]) : 0;
        j = i;
        while (j > 0 && row[j - 1] > val) begin
          row[j] = row[j - 1];
          j--;
        end
        row[j] = val;
      end
      median = row[MEDIAN_IDX];
      diff = (median > grey) ? median - grey : grey - median;
      res.motion = (diff > int'(threshold_q));
      res.frame_end = last;
      motion_due.push_back(res);
    end

    // Advance the raster position; a frame end moves on to the next slot.
    if (last) begin
      pos_q = 0;
      if (slot_q == HISTORY_DEPTH - 1) begin
        filled_q = 1'b1;
      end
      slot_q = (slot_q + 1) % HISTORY_DEPTH;
    end else begin
      pos_q = pos_q + 1;
    end
  endtask

  // Results are checked before the pixel of the same edge is absorbed, since
  // no result can belong to a pixel accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_due.delete();
      threshold_q = THRESH_RESET;
      frame_len_q = FRAME_LEN_RESET;
      slot_q      = 0;
      filled_q    = 1'b0;
      pos_q       = 0;
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (motion_due.size() == 0) begin
          $error("result with no request pending: motion %0d, frame_end %0d",
                 res_data_i[0], res_last_i);
          mismatches++;
        end else begin
          oldest_due = motion_due.pop_front();
          if (res_data_i[0] !== oldest_due.motion) begin
            $error("motion: expected %0d, actual %0d", oldest_due.motion, res_data_i[0]);
            mismatches++;
          end
          if (res_last_i !== oldest_due.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", oldest_due.frame_end, res_last_i);
            mismatches++;
          end
          if (res_data_i[7:1] !== 7'd0) begin
            $error("padding: expected %0d, actual %0d", 7'd0, res_data_i[7:1]);
            mismatches++;
          end
        end
      end

      if (pix_valid_i && pix_ready_i) begin
        absorb_pixel(pix_data_i);
      end

      // Register writes, decoded from the word address.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_THRESHOLD) begin
          threshold_q = pwdata_i[THRESH_W-1:0];
        end else begin
          frame_len_q = pwdata_i[FRAME_LEN_W-1:0];
        end
      end

      pending_o    <= motion_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- verif/tb_temporal_median_motion_mask.sv -----
// Testbench top for the temporal median motion mask: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_temporal_median_motion_mask;
  import tmm_pkg::*;

  // Largest frame used once results flow; every position below it is fully written.
  localparam int TEST_FRAME     = 16;
  localparam int RANDOM_ITEMS   = 500;
  localparam int CALM_ITEMS     = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // motion [0], zero padding [7:1]
  logic        m_axis_tlast;   // frame_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int idle_cycles;
  int stall_left;
  int stall_pct;
  int gap_pct;
  bit calm;

  temporal_median_motion_mask DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tmm_motion_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_last_i   (m_axis_tlast),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side back-pressure: random stall bursts of random length, none while calm.
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= (stall_left == 1);
      end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
        stall_left    <= $urandom_range(1, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no request of any channel is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("temporal_median_motion_mask: mismatch");
        $finish;
      end
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one pixel, after an optional gap, and return at the edge that accepts it.
  task automatic send_pixel(input logic [23:0] px);
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly a still scene near the given level with a little noise, sometimes anything.
  function automatic logic [23:0] make_pixel(input int level);
    logic [7:0] base;
    base = level[7:0];
    if ($urandom_range(0, 3) == 0) begin
      return 24'($urandom);
    end
    return {base + 8'($urandom_range(0, 7)), base + 8'($urandom_range(0, 7)),
            base + 8'($urandom_range(0, 7))};
  endfunction

  initial begin
    int level;
    int sent;
    int phase_len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    stall_pct     = 20;
    gap_pct       = 20;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Before the history fills: an oversized frame, then the largest one.
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_FRAME_PIXELS, 32'h7FFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    drain_results();
    write_reg(REG_FRAME_PIXELS, 32'(MAX_PIXELS));
    send_pixel(24'h80FF01);
    drain_results();

    // Shrink to the test frame and fill every slot of every position.
    write_reg(REG_FRAME_PIXELS, 32'(TEST_FRAME));
    level = 100;
    repeat (TEST_FRAME - 3 + (HISTORY_DEPTH - 1) * TEST_FRAME) begin
      send_pixel(make_pixel(level));
    end
    drain_results();

    // Grey extremes and rounding with a zero threshold.
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFE);
    send_pixel(24'h000102);
    send_pixel(24'h000002);
    send_pixel(24'h646464);
    send_pixel(24'hAA55AA);
    send_pixel(24'h55AA55);
    drain_results();

    // Largest threshold: no difference can exceed it.
    write_reg(REG_THRESHOLD, 32'd255);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    drain_results();

    // Frame shrunk below the current position: the next pixel closes the frame.
    write_reg(REG_FRAME_PIXELS, 32'd3);
    repeat (4) send_pixel(make_pixel(level));
    drain_results();

    // Zero frame length behaves as a single pixel per frame.
    write_reg(REG_FRAME_PIXELS, 32'd0);
    write_reg(REG_THRESHOLD, 32'(THRESH_RESET));
    repeat (3) send_pixel(make_pixel(level));
    drain_results();

    // Random phases, each with its own settings, written while the block is idle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_THRESHOLD, 32'd0);
          1:       write_reg(REG_THRESHOLD, 32'd255);
          default: write_reg(REG_THRESHOLD, 32'($urandom_range(0, 40)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_FRAME_PIXELS, 32'd0);
          1:       write_reg(REG_FRAME_PIXELS, 32'(TEST_FRAME));
          default: write_reg(REG_FRAME_PIXELS, 32'($urandom_range(1, TEST_FRAME)));
        endcase
      end
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      level     = $urandom_range(0, 248);
      phase_len = $urandom_range(10, 60);
      repeat (phase_len) begin
        send_pixel(make_pixel(level));
        sent++;
      end
      drain_results();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("temporal_median_motion_mask: match");
    end else begin
      $display("temporal_median_motion_mask: mismatch");
    end
    $finish;
  end

endmodule
